FILE: rtl/core/lkrm_pkg.sv
// Package for the latched key register map unit.
// Holds the command codes, register indexes, key bits and reset values.
// It has no dependencies.
`default_nettype none

package lkrm_pkg;

  localparam int unsigned MAP_DEPTH_DEF = 256;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_MATCH = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_SET   = 3'd4
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_REBOOT_HOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTORY_HOLD = 1'b1;

  localparam logic [BYTE_W-1:0] REBOOT_BIT  = 8'h02;
  localparam logic [BYTE_W-1:0] FACTORY_BIT = 8'h04;

  localparam logic [BYTE_W-1:0] REBOOT_HOLD_RST  = 8'd10;
  localparam logic [BYTE_W-1:0] FACTORY_HOLD_RST = 8'd120;
  localparam logic [BYTE_W-1:0] HOLD_MAX         = 8'hff;

endpackage

`default_nettype wire

FILE: rtl/core/latched_key_register_map_unit.sv
// Top level of the latched key register map unit.
// Holds the key byte memory, the bus pointer and the button hold counter.
// Depends on lkrm_pkg.
`default_nettype none

// The unit takes one command per clock cycle unless its input stalls, and
// returns one result for every command through the s1 registers and the
// result register. A command is decoded and its key byte is read from the
// map memory in the cycle of its transfer; as it leaves the s1 registers,
// the set and clear masks are merged into that byte, it is written back and
// the result register is loaded. Back-to-back accesses to the same byte are
// forwarded, so every command sees all earlier ones. The map reads as zero
// after reset through one valid flag per byte, so no clearing pass is needed.
module latched_key_register_map_unit
  import lkrm_pkg::*;
#(
  parameter int unsigned MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [BYTE_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [CMD_W-1:0]     command_i,
  input  wire logic                 is_write_i,
  input  wire logic [BYTE_W-1:0]    data_i,
  input  wire logic [BYTE_W-1:0]    port_i,
  input  wire logic                 button_level_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [BYTE_W-1:0]         read_data_o,
  output logic                      read_valid_o
);

  localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned CODES = 1 << BYTE_W;

  typedef logic [AW-1:0] wrap_tbl_t [CODES];

  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t tbl;
    for (int i = 0; i < CODES; i++) begin
      tbl[i] = AW'(i % MAP_DEPTH);
    end
    return tbl;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap();
  localparam logic [AW-1:0] PTR_LAST = AW'(MAP_DEPTH - 1);

  logic [BYTE_W-1:0] reboot_hold_q;
  logic [BYTE_W-1:0] factory_hold_q;

  logic [AW-1:0]     ptr_q, ptr_d;
  logic              load_pend_q, load_pend_d;
  logic [BYTE_W-1:0] hold_q, hold_d;
  logic [BYTE_W-1:0] hold_inc;

  logic              in_xfer;
  logic [AW-1:0]     acc_addr;
  logic [BYTE_W-1:0] acc_clr;
  logic [BYTE_W-1:0] acc_set;
  logic              acc_we;
  logic              acc_rd;

  logic              s1_valid_q;
  logic [AW-1:0]     s1_addr_q;
  logic [BYTE_W-1:0] s1_clr_q;
  logic [BYTE_W-1:0] s1_set_q;
  logic              s1_we_q;
  logic              s1_rd_q;
  logic              s1_fwd_q;
  logic [BYTE_W-1:0] s1_fwd_data_q;
  logic              s1_move;
  logic              s1_mem_we;
  logic [BYTE_W-1:0] s1_old;
  logic [BYTE_W-1:0] s1_new;

  logic [BYTE_W-1:0]    key_mem [MAP_DEPTH];
  logic [BYTE_W-1:0]    mem_rd_q;
  logic [MAP_DEPTH-1:0] vld_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] read_data_q;
  logic              read_valid_q;

  assign s1_move    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign hold_inc = (hold_q == HOLD_MAX) ? hold_q : hold_q + 1'b1;

  always_comb begin
    ptr_d       = ptr_q;
    load_pend_d = load_pend_q;
    hold_d      = hold_q;
    acc_addr    = ptr_q;
    acc_clr     = '0;
    acc_set     = '0;
    acc_we      = 1'b0;
    acc_rd      = 1'b0;
    unique case (command_i)
      CMD_MATCH: begin
        if (is_write_i) begin
          load_pend_d = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (load_pend_q) begin
          ptr_d       = WRAP_TBL[data_i];
          load_pend_d = 1'b0;
        end else begin
          acc_clr = data_i;
          acc_we  = 1'b1;
          ptr_d   = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
        end
      end
      CMD_READ: begin
        acc_rd = 1'b1;
        ptr_d  = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
      end
      CMD_TICK: begin
        acc_addr = '0;
        if (button_level_i) begin
          if (hold_q > reboot_hold_q) begin
            acc_set = REBOOT_BIT;
            acc_we  = 1'b1;
          end
          hold_d = '0;
        end else if (hold_inc > factory_hold_q) begin
          acc_set = FACTORY_BIT;
          acc_we  = 1'b1;
          hold_d  = '0;
        end else begin
          hold_d = hold_inc;
        end
      end
      CMD_SET: begin
        acc_addr = WRAP_TBL[port_i];
        acc_set  = data_i;
        acc_we   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign s1_old    = s1_fwd_q ? s1_fwd_data_q :
                     (vld_q[s1_addr_q] ? mem_rd_q : '0);
  assign s1_new    = (s1_old & ~s1_clr_q) | s1_set_q;
  assign s1_mem_we = s1_move && s1_we_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reboot_hold_q  <= REBOOT_HOLD_RST;
      factory_hold_q <= FACTORY_HOLD_RST;
      ptr_q          <= '0;
      load_pend_q    <= 1'b0;
      hold_q         <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      vld_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REBOOT_HOLD:  reboot_hold_q  <= cfg_data_i;
          REG_FACTORY_HOLD: factory_hold_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        ptr_q       <= ptr_d;
        load_pend_q <= load_pend_d;
        hold_q      <= hold_d;
        s1_valid_q  <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_mem_we) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_addr_q     <= acc_addr;
      s1_clr_q      <= acc_clr;
      s1_set_q      <= acc_set;
      s1_we_q       <= acc_we;
      s1_rd_q       <= acc_rd;
      s1_fwd_q      <= s1_mem_we && (s1_addr_q == acc_addr);
      s1_fwd_data_q <= s1_new;
    end
    if (s1_move) begin
      read_data_q  <= s1_rd_q ? s1_old : '0;
      read_valid_q <= s1_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_mem_we) begin
      key_mem[s1_addr_q] <= s1_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mem_rd_q <= key_mem[acc_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign read_valid_o = read_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/lkrm_checker.sv
// Port checker for the latched key register map unit, with its bind.
// Watches the handshakes and the result fields over time.
// Depends on lkrm_pkg and latched_key_register_map_unit.
`default_nettype none

module lkrm_checker
  import lkrm_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [BYTE_W-1:0] read_data_o,
  input wire logic              read_valid_o
);

  // A stalled result must stay in place until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(read_data_o) && $stable(read_valid_o))
    else $error("Stalled result changed before its transfer.");

  // Only a read returns a nonzero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == '0)
    else $error("Result that answers no read carries data.");

  // The input side stalls only when a finished result is held up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the output can move.");

  // A command taken with an empty output and no stall shows up in time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o && !out_stall_i |=> ##1 out_valid_o)
    else $error("Result of a transfer did not appear.");

endmodule

bind latched_key_register_map_unit lkrm_checker u_lkrm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_data_o  (read_data_o),
  .read_valid_o (read_valid_o)
);

`default_nettype wire
